FILE: rtl/core/brf_pkg.sv
// Shared types, sizes and helpers for the ring byte FIFO.
`default_nettype none
package brf_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_BURST = 64;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = PTR_W + 1;
  localparam int HANDLED_W = 7;
  localparam int CMP_W     = (CNT_W > HANDLED_W) ? CNT_W : HANDLED_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_PEEK   = 2'd1,
    ACT_POP    = 2'd2,
    ACT_DROP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } state_t;

  typedef struct packed {
    logic insert;
    logic drop;
    logic single;
    logic start_rd;
    logic rd_issue;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic n_zero;
    logic last;
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/brf_ctrl.sv
// Control state machine for the ring byte FIFO.
`default_nettype none
module brf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire brf_pkg::action_t  in_action,
  input  wire brf_pkg::status_t  status,
  output brf_pkg::cmd_t          cmd
);

  import brf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          case (in_action)
            ACT_INSERT: begin
              cmd.insert = 1'b1;
              cmd.single = 1'b1;
            end
            ACT_DROP: begin
              cmd.drop   = 1'b1;
              cmd.single = 1'b1;
            end
            default: begin
              if (status.n_zero) begin
                cmd.single = 1'b1;
              end else begin
                cmd.start_rd = 1'b1;
                state_nxt    = ST_RD_ISSUE;
              end
            end
          endcase
        end
      end
      ST_RD_ISSUE: begin
        if (status.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_RD_LOAD;
        end
      end
      ST_RD_LOAD: begin
        cmd.rd_load = 1'b1;
        state_nxt   = status.last ? ST_IDLE : ST_RD_ISSUE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/brf_dp.sv
// Datapath of the ring byte FIFO: pointers, free count, store and result register.
`default_nettype none
module brf_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire brf_pkg::cmd_t                      cmd,
  output brf_pkg::status_t                        status,
  input  wire brf_pkg::action_t                   in_action,
  input  wire logic [7:0]                         in_byte,
  input  wire logic [6:0]                         in_count,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_byte,
  output logic                                    out_out_valid,
  output logic                                    out_last,
  output logic [brf_pkg::HANDLED_W-1:0]           out_handled
);

  import brf_pkg::*;

  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [CNT_W-1:0]     free_r;
  logic [PTR_W-1:0]     p_r;
  logic [HANDLED_W-1:0] rem_r;
  logic [HANDLED_W-1:0] n_r;
  logic                 pop_r;
  logic                 last_r;
  logic                 ovld_r;
  logic [7:0]           obyte_r;
  logic                 oval_r;
  logic                 olast_r;
  logic [HANDLED_W-1:0] ohand_r;

  logic [HANDLED_W-1:0] cnt_sat;
  logic [CNT_W-1:0]     used;
  logic [CMP_W-1:0]     used_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [HANDLED_W-1:0] n;
  logic                 ins_ok;
  logic [HANDLED_W-1:0] h_single;
  logic [SUM_W-1:0]     drop_sum;
  logic [PTR_W-1:0]     drop_ptr;
  logic [7:0]           rdata;

  assign cnt_sat  = (in_count > HANDLED_W'(MAX_BURST)) ? HANDLED_W'(MAX_BURST) : in_count;
  assign used     = CNT_W'(DEPTH) - free_r;
  assign used_ext = CMP_W'(used);
  assign cnt_ext  = CMP_W'(cnt_sat);
  assign n        = (used_ext < cnt_ext) ? used_ext[HANDLED_W-1:0] : cnt_sat;
  assign ins_ok   = (free_r != '0);
  assign h_single = (in_action == ACT_INSERT) ? HANDLED_W'(ins_ok) : n;

  assign drop_sum = {1'b0, rd_ptr_r} + SUM_W'(n);
  assign drop_ptr = (drop_sum >= SUM_W'(DEPTH)) ? PTR_W'(drop_sum - SUM_W'(DEPTH))
                                                 : drop_sum[PTR_W-1:0];

  assign status.out_free = !ovld_r || out_ready;
  assign status.n_zero   = (n == '0);
  assign status.last     = last_r;

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.insert && ins_ok),
    .waddr (wr_ptr_r),
    .wdata (in_byte),
    .re    (cmd.rd_issue),
    .raddr (p_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      free_r   <= CNT_W'(DEPTH);
      ovld_r   <= 1'b0;
    end else begin
      if (cmd.insert && ins_ok) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
        free_r   <= free_r - CNT_W'(1);
      end
      if (cmd.drop) begin
        rd_ptr_r <= drop_ptr;
        free_r   <= free_r + CNT_W'(n);
      end
      if (cmd.rd_load && last_r && pop_r) begin
        rd_ptr_r <= p_r;
        free_r   <= free_r + CNT_W'(n_r);
      end
      if (cmd.single || cmd.rd_load) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_rd) begin
      p_r   <= rd_ptr_r;
      rem_r <= n;
      n_r   <= n;
      pop_r <= (in_action == ACT_POP);
    end
    if (cmd.rd_issue) begin
      p_r    <= ptr_inc(p_r);
      rem_r  <= rem_r - HANDLED_W'(1);
      last_r <= (rem_r == HANDLED_W'(1));
    end
    if (cmd.single) begin
      obyte_r <= '0;
      oval_r  <= 1'b0;
      olast_r <= 1'b1;
      ohand_r <= h_single;
    end
    if (cmd.rd_load) begin
      obyte_r <= rdata;
      oval_r  <= 1'b1;
      olast_r <= last_r;
      ohand_r <= n_r;
    end
  end

  assign out_valid     = ovld_r;
  assign out_byte      = obyte_r;
  assign out_out_valid = oval_r;
  assign out_last      = olast_r;
  assign out_handled   = ohand_r;

endmodule
`default_nettype wire

FILE: rtl/core/byte_ring_fifo_peek_drop.sv
// Top level of the ring byte FIFO with insert, peek, pop and drop.
// One word is taken at a time. Insert, drop and a peek or pop that finds
// nothing to read give their single result in the cycle after acceptance,
// and the next word may enter as soon as that result is taken. A peek or
// pop of n bytes streams n results, each read from the registered read
// port of the 1024-byte store once the one output register is free; the
// next word is accepted once the last byte's result is taken, at the
// earliest in the same cycle. The store needs no clearing pass after reset.
`default_nettype none
module byte_ring_fifo_peek_drop (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire brf_pkg::action_t                   in_action,
  input  wire logic [7:0]                         in_byte,
  input  wire logic [6:0]                         in_count,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_byte,
  output logic                                    out_out_valid,
  output logic                                    out_last,
  output logic [brf_pkg::HANDLED_W-1:0]           out_handled
);

  import brf_pkg::*;

  cmd_t    cmd;
  status_t status;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .status    (status),
    .cmd       (cmd)
  );

  brf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_action     (in_action),
    .in_byte       (in_byte),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_out_valid (out_out_valid),
    .out_last      (out_last),
    .out_handled   (out_handled)
  );

endmodule
`default_nettype wire
